/* rtl/cel_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross entropy loss reduce package
// Shared widths, the item that travels through the queue, and the constant
// log tables used by the front end.
// ----------------------------------------------------------------------------
package cel_pkg;

    localparam int unsigned MAX_ELEMENTS_DEF = 1048576;
    localparam int unsigned PROB_FRAC_BITS   = 16;
    localparam int unsigned LOG_TABLE_BITS   = 8;
    localparam int unsigned TABLE_SIZE       = 1 << LOG_TABLE_BITS;

    localparam int unsigned PRED_W   = 16;
    localparam int unsigned TARGET_W = 17;
    localparam int unsigned LOSS_W   = 24;
    localparam int unsigned NEGLOG_W = 20;
    localparam int unsigned TERM_W   = 22;
    localparam int unsigned SUM_W    = 56;
    localparam int unsigned COUNT_W  = 21;
    localparam int unsigned KPOS_W   = 4;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QLVL_W      = 3;

    localparam logic [63:0] LN2_Q32 = 64'd2977044472;

    typedef logic [15:0] t_ln_tab [TABLE_SIZE];
    typedef logic [NEGLOG_W-1:0] t_oct_tab [PRED_W];

    // One classified pair waiting for the accumulator.
    typedef struct packed {
        logic [TERM_W-1:0] term;
        logic              last;
    } t_item;

    // ln(1 + i / TABLE_SIZE) in Q0.16, log2 by repeated squaring, rounded half up.
    function automatic t_ln_tab build_ln_table();
        t_ln_tab     tab;
        logic [63:0] x;
        logic [63:0] lg;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            x  = (64'd1 << 30) + ((64'(i) << 30) >> LOG_TABLE_BITS);
            lg = 64'd0;
            for (int b = 0; b < 32; b++) begin
                x  = (x * x) >> 30;
                lg = lg << 1;
                if (x >= (64'd2 << 30)) begin
                    x  = x >> 1;
                    lg = lg | 64'd1;
                end
            end
            tab[i] = 16'((lg * LN2_Q32 + (64'd1 << 47)) >> 48);
        end
        return tab;
    endfunction

    // (F - k) * ln2 in Q.16, rounded half up, for each leading-one position k.
    function automatic t_oct_tab build_oct_table();
        t_oct_tab tab;
        for (int k = 0; k < PRED_W; k++) begin
            tab[k] = NEGLOG_W'((64'(PROB_FRAC_BITS - k) * LN2_Q32 + (64'd1 << 15)) >> 16);
        end
        return tab;
    endfunction

    localparam t_ln_tab  LN_TABLE  = build_ln_table();
    localparam t_oct_tab OCT_TABLE = build_oct_table();

endpackage

/* rtl/cel_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross entropy loss front end
// Clips each prediction, forms -ln(p), weights it by the target and pushes
// the term into the queue. Two stages; admission is by credit on the queue.
// ----------------------------------------------------------------------------
module cel_front import cel_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [PRED_W-1:0]   i_prediction,
    input  logic [TARGET_W-1:0] i_target,
    input  logic                i_last,
    input  logic [QLVL_W-1:0]   i_q_level,
    output logic                o_push,
    output t_item               o_item
);

    logic                  r_a_valid;
    logic [NEGLOG_W-1:0]   r_a_neglog;
    logic [TARGET_W-1:0]   r_a_target;
    logic                  r_a_last;
    logic                  r_b_valid;
    t_item                 r_b_item;

    logic [PRED_W-1:0]     p_clip;
    logic [KPOS_W-1:0]     kpos;
    logic [PRED_W-1:0]     p_norm;
    logic [15:0]           ln_mant;
    logic [NEGLOG_W-1:0]   octave;
    logic [NEGLOG_W-1:0]   n_a_neglog;
    logic [TARGET_W+NEGLOG_W:0] product;
    logic                  accept;

    // Entries in flight in the two stages each hold a queue slot in reserve.
    assign o_stall = (QLVL_W'(32'(i_q_level) + 32'(r_a_valid) + 32'(r_b_valid))
                      >= QLVL_W'(QUEUE_DEPTH));
    assign accept  = i_valid && !o_stall;

    always_comb begin
        p_clip = (i_prediction == '0) ? PRED_W'(1) : i_prediction;
        kpos   = '0;
        for (int t = 0; t < PRED_W; t++) begin
            if (p_clip[t]) begin
                kpos = KPOS_W'(t);
            end
        end
        p_norm     = p_clip << (KPOS_W'(PRED_W - 1) - kpos);
        ln_mant    = LN_TABLE[p_norm[PRED_W-2 -: LOG_TABLE_BITS]];
        octave     = OCT_TABLE[kpos];
        n_a_neglog = (octave < NEGLOG_W'(ln_mant)) ? '0 : octave - NEGLOG_W'(ln_mant);
    end

    assign product = (TARGET_W+NEGLOG_W+1)'(r_a_target) * (TARGET_W+NEGLOG_W+1)'(r_a_neglog)
                   + (TARGET_W+NEGLOG_W+1)'(1 << (PROB_FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
        end
        if (accept) begin
            r_a_neglog <= n_a_neglog;
            r_a_target <= i_target;
            r_a_last   <= i_last;
        end
        if (r_a_valid) begin
            r_b_item.term <= TERM_W'(product >> PROB_FRAC_BITS);
            r_b_item.last <= r_a_last;
        end
    end

    assign o_push = r_b_valid;
    assign o_item = r_b_item;

endmodule

/* rtl/cel_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross entropy loss term queue
// Small first-in first-out buffer between the front end and the accumulator.
// ----------------------------------------------------------------------------
module cel_queue import cel_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_item             i_item,
    input  logic              i_pop,
    output logic              o_valid,
    output t_item             o_item,
    output logic [QLVL_W-1:0] o_level
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QLVL_W-1:0]  r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_level <= r_level + QLVL_W'(i_push) - QLVL_W'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_item  = r_mem[r_rd];
    assign o_level = r_level;

endmodule

/* rtl/cel_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross entropy loss back end
// Accumulates terms with saturation, counts pairs, and on the last pair
// divides the rounded sum by the count one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cel_back import cel_pkg::*; #(
    parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_item             i_q_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [LOSS_W-1:0] o_loss,
    output logic              o_overflow
);

    localparam int unsigned   COUNT_MAX   = (1 << COUNT_W) - 1;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        COUNT_W'((MAX_ELEMENTS > COUNT_MAX) ? COUNT_MAX : MAX_ELEMENTS);
    localparam int unsigned   DIVIDEND_W  = SUM_W + 1;
    localparam int unsigned   STEP_W      = $clog2(DIVIDEND_W);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                  r_state;
    logic [SUM_W-1:0]        r_sum;
    logic [COUNT_W-1:0]      r_count;
    logic                    r_sat;
    logic [DIVIDEND_W-1:0]   r_quo;
    logic [COUNT_W-1:0]      r_rem;
    logic [COUNT_W-1:0]      r_div;
    logic [STEP_W-1:0]       r_step;
    logic                    r_div_sat;
    logic [LOSS_W-1:0]       r_loss;
    logic                    r_ovf;

    logic [SUM_W:0]          sum_ext;
    logic [COUNT_W:0]        trial;
    logic                    fits;

    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign sum_ext = {1'b0, r_sum} + (SUM_W+1)'(i_q_item.term);
    assign trial   = {r_rem, r_quo[DIVIDEND_W-1]};
    assign fits    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_count <= '0;
            r_sat   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (sum_ext[SUM_W]) begin
                            r_sum <= '1;
                            r_sat <= 1'b1;
                        end else begin
                            r_sum <= sum_ext[SUM_W-1:0];
                        end
                        if (r_count < COUNT_LIMIT) begin
                            r_count <= r_count + COUNT_W'(1);
                        end else begin
                            r_sat <= 1'b1;
                        end
                        if (i_q_item.last) begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    // Round half up, then clear the set for the next one.
                    r_quo     <= DIVIDEND_W'(r_sum) + DIVIDEND_W'(r_count >> 1);
                    r_div     <= (r_count == '0) ? COUNT_W'(1) : r_count;
                    r_rem     <= '0;
                    r_step    <= STEP_W'(DIVIDEND_W - 1);
                    r_div_sat <= r_sat;
                    r_sum     <= '0;
                    r_count   <= '0;
                    r_sat     <= 1'b0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= fits ? COUNT_W'(trial - {1'b0, r_div}) : COUNT_W'(trial);
                    r_quo  <= {r_quo[DIVIDEND_W-2:0], fits};
                    r_step <= r_step - STEP_W'(1);
                    if (r_step == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (r_state == S_DIV && r_step == '0) begin
            if (|{r_quo[DIVIDEND_W-2:LOSS_W-1]}) begin
                r_loss <= '1;
                r_ovf  <= 1'b1;
            end else begin
                r_loss <= {r_quo[LOSS_W-2:0], fits};
                r_ovf  <= r_div_sat;
            end
        end
    end

    assign o_valid    = (r_state == S_OUT);
    assign o_loss     = r_loss;
    assign o_overflow = r_ovf;

endmodule

/* rtl/cross_entropy_loss_reduce_unit.sv */
`timescale 1ns / 1ps
// Path: a pair marked last gives its loss after acceptance through the second front
// stage, the queue write, the accumulate step and the rounding step (S_PREP), then the
// bit-serial divider (S_DIV).
// Throughput: one pair per cycle while the queue has room, until a last pair. The divider
// then holds the accumulator, plus any output stall, while the front keeps filling the queue.
// Reset: synchronous, active low; clears the sums, count, queue and all valids.
// ----------------------------------------------------------------------------
// Cross entropy loss reduce unit
// Mean categorical cross entropy over a stream of probability and target
// pairs, in Q8.16 fixed point.
// ----------------------------------------------------------------------------
module cross_entropy_loss_reduce_unit import cel_pkg::*; #(
    parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [PRED_W-1:0]   i_prediction,
    input  logic [TARGET_W-1:0] i_target,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [LOSS_W-1:0]   o_loss,
    output logic                o_overflow
);

    // The front end classifies each input transaction into one weighted term.
    // It never blocks internally; it only refuses a transaction when the queue
    // could not take a new term on top of every term already in flight.
    logic              push;
    t_item             push_item;
    logic              pop;
    logic              q_valid;
    t_item             q_item;
    logic [QLVL_W-1:0] q_level;

    cel_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_prediction (i_prediction),
        .i_target     (i_target),
        .i_last       (i_last),
        .i_q_level    (q_level),
        .o_push       (push),
        .o_item       (push_item)
    );

    // The queue lets the front keep accepting while the back end divides or
    // waits for the downstream side to take a result.
    cel_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_level (q_level)
    );

    // The back end accumulates terms and, at the end of each set, produces
    // the rounded mean through its serial divider and an output register.
    cel_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_loss     (o_loss),
        .o_overflow (o_overflow)
    );

endmodule

/* rtl/cel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross entropy loss port checker
// Watches the top level ports for handshake and result spacing rules.
// ----------------------------------------------------------------------------
module cel_checker import cel_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [LOSS_W-1:0] o_loss,
    input logic              o_overflow
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_loss) && $stable(o_overflow)))
        else $error("result payload changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_valid)
        else $error("results delivered back to back");

endmodule

bind cross_entropy_loss_reduce_unit cel_checker u_cel_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_loss     (o_loss),
    .o_overflow (o_overflow)
);
